[rtl/tbr_pkg.sv]
// Shared codes and constants for the per-task and global token bucket limiter.
package tbr_pkg;

  localparam int PADDR_W = 3;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_REQ  = 2'd1;
  localparam logic [1:0] ACT_SET  = 2'd2;

  localparam logic [2:0] STS_GRANT        = 3'd0;
  localparam logic [2:0] STS_TASK_SHORT   = 3'd1;
  localparam logic [2:0] STS_GLOBAL_SHORT = 3'd2;
  localparam logic [2:0] STS_TOO_LARGE    = 3'd3;
  localparam logic [2:0] STS_DONE         = 3'd4;

  localparam logic REG_GLOBAL_RATE = 1'b0;

endpackage

[rtl/per_task_and_global_token_bucket.sv]
// Per-task and global token bucket limiter, top level.
// Sequence: task memory read, refill multiply, then update/write-back; the result
// strobe (done) is registered at the end of the update. One item at a time: a new
// start transfer is taken only while busy is low.
// Reset: synchronous; clears time, global bucket and all task rates (valid bits).
module per_task_and_global_token_bucket #(
  parameter int NUM_TASKS  = 64,
  parameter int TICK_SHIFT = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic [5:0]                   task_req,
  input  logic [31:0]                  amount_bytes,
  input  logic [31:0]                  new_rate,
  output logic                         done,
  output logic [2:0]                   status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tbr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tbr_pkg::*;

  localparam int DEPTH = (NUM_TASKS < 64) ? NUM_TASKS : 64;
  localparam int TOK_W = 32 + TICK_SHIFT;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  typedef struct packed {
    logic [31:0]      rate;
    logic [TOK_W-1:0] tokens;
    logic [31:0]      stamp;
  } task_ent_t;

  task_ent_t mem [DEPTH];

  logic [1:0]       state;
  logic [31:0]      time_now;
  logic [31:0]      global_rate;
  logic [TOK_W-1:0] global_tokens;
  logic [31:0]      global_stamp;
  logic [DEPTH-1:0] valid;

  logic [1:0]       act_q;
  logic [31:0]      amount_q;
  logic [31:0]      nrate_q;
  logic             task_ok_q;
  logic [IDX_W-1:0] idx_q;
  task_ent_t        rd_ent;
  logic             rd_valid;

  logic             accept;
  logic             task_ok;
  logic [IDX_W-1:0] rd_addr;
  logic             cfg_we;
  logic             cfg_hit;

  logic [31:0]      task_rate;
  logic [TOK_W-1:0] t_fill;
  logic [TOK_W-1:0] g_fill;
  logic [TOK_W-1:0] need;
  logic [TOK_W-1:0] capn;
  logic             use_task;
  logic             use_glob;
  logic             too_big;
  logic             t_short;
  logic             g_short;
  logic             grant;

  logic [2:0]       status_next;
  logic             mem_we;
  task_ent_t        mem_wdata;
  logic             valid_set;
  logic             valid_clr;
  logic             g_we;
  logic [TOK_W-1:0] g_tokens_next;
  logic             tick;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign task_ok = (32'(task_req) < 32'(NUM_TASKS));
  assign rd_addr = task_ok ? task_req[IDX_W-1:0] : '0;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready && (paddr[2] == REG_GLOBAL_RATE);
  assign cfg_hit = cfg_we && !((global_rate != 32'd0) && (global_rate == pwdata));
  assign prdata  = (paddr[2] == REG_GLOBAL_RATE) ? global_rate : 32'd0;

  assign task_rate = rd_valid ? rd_ent.rate : 32'd0;

  tbr_refill #(.TICK_SHIFT(TICK_SHIFT)) u_task_fill (
    .clk    (clk),
    .load   (state == S_MUL),
    .now    (time_now),
    .stamp  (rd_ent.stamp),
    .rate   (task_rate),
    .tokens (rd_ent.tokens),
    .fill   (t_fill)
  );

  tbr_refill #(.TICK_SHIFT(TICK_SHIFT)) u_glob_fill (
    .clk    (clk),
    .load   (state == S_MUL),
    .now    (time_now),
    .stamp  (global_stamp),
    .rate   (global_rate),
    .tokens (global_tokens),
    .fill   (g_fill)
  );

  assign need     = TOK_W'(amount_q) << TICK_SHIFT;
  assign capn     = TOK_W'(nrate_q) << TICK_SHIFT;
  assign use_task = task_ok_q && (task_rate != 32'd0);
  assign use_glob = (global_rate != 32'd0);
  assign too_big  = (use_task && (amount_q > task_rate)) || (use_glob && (amount_q > global_rate));
  assign t_short  = use_task && (t_fill < need);
  assign g_short  = use_glob && (g_fill < need);
  assign grant    = !too_big && !t_short && !g_short;

  always_comb begin
    status_next   = STS_DONE;
    mem_we        = 1'b0;
    mem_wdata     = rd_ent;
    valid_set     = 1'b0;
    valid_clr     = 1'b0;
    g_we          = 1'b0;
    g_tokens_next = g_fill;
    tick          = 1'b0;
    unique case (act_q)
      ACT_TICK: begin
        tick = 1'b1;
      end
      ACT_REQ: begin
        status_next = STS_GRANT;
        if (amount_q != 32'd0) begin
          priority if (too_big) begin
            status_next = STS_TOO_LARGE;
          end else if (t_short) begin
            status_next = STS_TASK_SHORT;
          end else if (g_short) begin
            status_next = STS_GLOBAL_SHORT;
          end else begin
            status_next = STS_GRANT;
          end
          mem_we          = use_task;
          mem_wdata.rate  = task_rate;
          mem_wdata.tokens = grant ? (t_fill - need) : t_fill;
          mem_wdata.stamp = time_now;
          g_we            = use_glob;
          g_tokens_next   = grant ? (g_fill - need) : g_fill;
        end
      end
      ACT_SET: begin
        if (task_ok_q) begin
          mem_wdata.rate  = nrate_q;
          mem_wdata.stamp = time_now;
          priority if (nrate_q == 32'd0) begin
            valid_clr = 1'b1;
          end else if (task_rate == 32'd0) begin
            mem_we           = 1'b1;
            valid_set        = 1'b1;
            mem_wdata.tokens = capn;
          end else if (task_rate != nrate_q) begin
            mem_we           = 1'b1;
            mem_wdata.tokens = (t_fill > capn) ? capn : t_fill;
          end
        end
      end
      default: begin
        status_next = STS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state == S_UPD) && mem_we) begin
      mem[idx_q] <= mem_wdata;
    end
    if (accept) begin
      rd_ent <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q     <= action;
      amount_q  <= amount_bytes;
      nrate_q   <= new_rate;
      task_ok_q <= task_ok;
      idx_q     <= rd_addr;
    end
    if (state == S_UPD) begin
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      time_now      <= 32'd0;
      global_rate   <= 32'd0;
      global_tokens <= '0;
      global_stamp  <= 32'd0;
      valid         <= '0;
      rd_valid      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        rd_valid <= valid[rd_addr];
      end
      if (cfg_hit) begin
        global_rate   <= pwdata;
        global_tokens <= TOK_W'(pwdata) << TICK_SHIFT;
        global_stamp  <= time_now;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_UPD;
        end
        S_UPD: begin
          state <= S_IDLE;
          done  <= 1'b1;
          if (tick) begin
            time_now <= time_now + 32'd1;
          end
          if (g_we) begin
            global_tokens <= g_tokens_next;
            global_stamp  <= time_now;
          end
          if (valid_set) begin
            valid[idx_q] <= 1'b1;
          end
          if (valid_clr) begin
            valid[idx_q] <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/tbr_refill.sv]
// Lazy bucket refill: elapsed-time product registered on load, add and clamp combinational from the registered values.
module tbr_refill #(
  parameter int TICK_SHIFT = 10
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic [31:0]            now,
  input  logic [31:0]            stamp,
  input  logic [31:0]            rate,
  input  logic [32+TICK_SHIFT-1:0] tokens,
  output logic [32+TICK_SHIFT-1:0] fill
);
  localparam int TOK_W = 32 + TICK_SHIFT;
  localparam int EL_W  = (TICK_SHIFT > 0) ? TICK_SHIFT : 1;
  localparam int PR_W  = EL_W + 32;
  localparam int SUM_W = TOK_W + 2;

  logic [31:0]       elapsed;
  logic              full_q;
  logic [PR_W-1:0]   prod_q;
  logic [TOK_W-1:0]  tokens_q;
  logic [31:0]       rate_q;
  logic [TOK_W-1:0]  cap;
  logic [SUM_W-1:0]  sum;

  assign elapsed = now - stamp;

  always_ff @(posedge clk) begin
    if (load) begin
      full_q   <= (elapsed >= (32'd1 << TICK_SHIFT));
      prod_q   <= PR_W'(elapsed[EL_W-1:0]) * PR_W'(rate);
      tokens_q <= tokens;
      rate_q   <= rate;
    end
  end

  assign cap = TOK_W'(rate_q) << TICK_SHIFT;
  assign sum = SUM_W'(tokens_q) + SUM_W'(prod_q);

  always_comb begin
    if (full_q || (sum > SUM_W'(cap))) begin
      fill = cap;
    end else begin
      fill = sum[TOK_W-1:0];
    end
  end

endmodule

[rtl/tbr_checker.sv]
// Port-level checks for the token bucket limiter, bound to the top level.
module tbr_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [2:0] status
);
  import tbr_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after start transfer");

  a_result_lat: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##3 done)
    else $error("result missing three cycles after start transfer");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe outside end of item");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status <= STS_DONE))
    else $error("undefined status code");

endmodule

bind per_task_and_global_token_bucket tbr_checker u_tbr_checker (.*);
